FILE: hw/rtl/gopd_pkg.sv
package gopd_pkg;

    // Default build values for the top-level parameters.
    localparam int POS_BITS_DEF        = 17;
    localparam int SCALE_FRAC_BITS_DEF = 24;

    // Fixed field widths.
    localparam int SCALE_W = 25;
    localparam int OUT_W   = 34;
    localparam int FLAG_W  = 8;
    localparam int RAW_W   = 16;
    localparam int DELTA_W = 17;

    // A point causes at most four results.
    localparam int MAX_RES = 4;
    localparam int CNT_W   = 3;
    localparam int IDX_W   = 2;

    // Bit positions inside the point flag byte.
    localparam int FLAG_ON_CURVE = 0;
    localparam int FLAG_X_SHORT  = 1;
    localparam int FLAG_Y_SHORT  = 2;
    localparam int FLAG_X_SAME   = 4;
    localparam int FLAG_Y_SAME   = 5;

    // Drawing command codes.
    typedef enum logic [2:0] {
        CMD_MOVE  = 3'd0,
        CMD_LINE  = 3'd1,
        CMD_BEZ   = 3'd2,
        CMD_CLOSE = 3'd3,
        CMD_FIXUP = 3'd4
    } cmd_t;

    // Command list built for one point: number of results and their codes.
    typedef struct packed {
        logic [CNT_W-1:0]   count;
        cmd_t [MAX_RES-1:0] cmd;
    } job_ctl_t;

    // Decode one coordinate delta: short magnitude with sign, unchanged, or int16.
    function automatic logic signed [DELTA_W-1:0] coord_delta(
        input logic             is_short,
        input logic             is_same,
        input logic [RAW_W-1:0] raw
    );
        logic signed [DELTA_W-1:0] mag;
        logic signed [DELTA_W-1:0] res;
        mag = DELTA_W'(raw[7:0]);
        if (is_short) begin
            res = is_same ? mag : -mag;
        end else if (is_same) begin
            res = '0;
        end else begin
            res = DELTA_W'($signed(raw));
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/gopd_decode.sv
module gopd_decode #(
    parameter int POS_BITS = gopd_pkg::POS_BITS_DEF
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            take,
    input  logic                                            glyph_start,
    input  logic [gopd_pkg::FLAG_W-1:0]                     flag,
    input  logic [gopd_pkg::RAW_W-1:0]                      x_raw,
    input  logic [gopd_pkg::RAW_W-1:0]                      y_raw,
    input  logic                                            contour_end,
    output gopd_pkg::job_ctl_t                              job_ctl,
    output logic [gopd_pkg::MAX_RES-1:0][POS_BITS:0]        op_ax,
    output logic [gopd_pkg::MAX_RES-1:0][POS_BITS:0]        op_ay,
    output logic [gopd_pkg::MAX_RES-1:0][POS_BITS:0]        op_bx,
    output logic [gopd_pkg::MAX_RES-1:0][POS_BITS:0]        op_by
);
    import gopd_pkg::*;

    // Operands carry twice the position, so a midpoint sum needs no extra shift.
    localparam int OP_W = POS_BITS + 1;

    logic signed [POS_BITS-1:0] pos_x_reg, pos_y_reg;
    logic signed [POS_BITS-1:0] first_x_reg, first_y_reg;
    logic                       prev_on_reg, pending_reg, start_off_reg;

    logic signed [DELTA_W-1:0]  dx, dy;
    logic signed [POS_BITS-1:0] base_x, base_y, new_x, new_y, first_x, first_y;
    logic                       on, opening, start_off;
    logic [OP_W-1:0]            mid_x, mid_y;

    logic                       r1_v;
    cmd_t                       r1_cmd;
    logic [OP_W-1:0]            r1_ax, r1_ay, r1_bx, r1_by;
    logic                       fx_v, cb_v;
    logic [OP_W-1:0]            fx_ax, fx_ay, cb_bx, cb_by;
    logic [CNT_W-1:0]           n;

    function automatic logic [OP_W-1:0] dbl(input logic signed [POS_BITS-1:0] p);
        return {p, 1'b0};
    endfunction

    function automatic logic [OP_W-1:0] add2(
        input logic signed [POS_BITS-1:0] a,
        input logic signed [POS_BITS-1:0] b
    );
        return OP_W'(a) + OP_W'(b);
    endfunction

    // New position and the contour context this point sees.
    always_comb begin
        on        = flag[FLAG_ON_CURVE];
        opening   = glyph_start | pending_reg;
        base_x    = glyph_start ? '0 : pos_x_reg;
        base_y    = glyph_start ? '0 : pos_y_reg;
        dx        = coord_delta(flag[FLAG_X_SHORT], flag[FLAG_X_SAME], x_raw);
        dy        = coord_delta(flag[FLAG_Y_SHORT], flag[FLAG_Y_SAME], y_raw);
        new_x     = base_x + POS_BITS'(dx);
        new_y     = base_y + POS_BITS'(dy);
        first_x   = opening ? new_x : first_x_reg;
        first_y   = opening ? new_y : first_y_reg;
        start_off = opening ? !on : start_off_reg;
        mid_x     = add2(new_x, first_x);
        mid_y     = add2(new_y, first_y);
    end

    // Candidate results: the point's own command, then the contour closing ones.
    always_comb begin
        r1_v   = 1'b1;
        r1_cmd = CMD_MOVE;
        r1_ax  = dbl(new_x);
        r1_ay  = dbl(new_y);
        r1_bx  = '0;
        r1_by  = '0;
        if (opening) begin
            r1_cmd = CMD_MOVE;
        end else if (on && prev_on_reg) begin
            r1_cmd = CMD_LINE;
        end else if (on) begin
            r1_cmd = CMD_BEZ;
            r1_ax  = dbl(base_x);
            r1_ay  = dbl(base_y);
            r1_bx  = dbl(new_x);
            r1_by  = dbl(new_y);
        end else if (!prev_on_reg) begin
            r1_cmd = CMD_BEZ;
            r1_ax  = dbl(base_x);
            r1_ay  = dbl(base_y);
            r1_bx  = add2(base_x, new_x);
            r1_by  = add2(base_y, new_y);
        end else begin
            r1_v = 1'b0;
        end

        fx_v  = contour_end & start_off;
        fx_ax = on ? dbl(new_x) : mid_x;
        fx_ay = on ? dbl(new_y) : mid_y;
        cb_v  = contour_end & !on;
        cb_bx = start_off ? mid_x : dbl(first_x);
        cb_by = start_off ? mid_y : dbl(first_y);
    end

    // Pack the candidates into consecutive slots.
    always_comb begin
        n             = '0;
        job_ctl.count = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            job_ctl.cmd[i] = CMD_CLOSE;
        end
        op_ax   = '0;
        op_ay   = '0;
        op_bx   = '0;
        op_by   = '0;
        if (r1_v) begin
            job_ctl.cmd[n[IDX_W-1:0]] = r1_cmd;
            op_ax[n[IDX_W-1:0]]       = r1_ax;
            op_ay[n[IDX_W-1:0]]       = r1_ay;
            op_bx[n[IDX_W-1:0]]       = r1_bx;
            op_by[n[IDX_W-1:0]]       = r1_by;
            n = n + CNT_W'(1);
        end
        if (fx_v) begin
            job_ctl.cmd[n[IDX_W-1:0]] = CMD_FIXUP;
            op_ax[n[IDX_W-1:0]]       = fx_ax;
            op_ay[n[IDX_W-1:0]]       = fx_ay;
            n = n + CNT_W'(1);
        end
        if (cb_v) begin
            job_ctl.cmd[n[IDX_W-1:0]] = CMD_BEZ;
            op_ax[n[IDX_W-1:0]]       = dbl(new_x);
            op_ay[n[IDX_W-1:0]]       = dbl(new_y);
            op_bx[n[IDX_W-1:0]]       = cb_bx;
            op_by[n[IDX_W-1:0]]       = cb_by;
            n = n + CNT_W'(1);
        end
        if (contour_end) begin
            job_ctl.cmd[n[IDX_W-1:0]] = CMD_CLOSE;
            n = n + CNT_W'(1);
        end
        job_ctl.count = n;
    end

    // Outline state advances once per accepted point.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            prev_on_reg   <= 1'b1;
            pending_reg   <= 1'b1;
            start_off_reg <= 1'b0;
        end else if (take) begin
            pos_x_reg     <= new_x;
            pos_y_reg     <= new_y;
            first_x_reg   <= first_x;
            first_y_reg   <= first_y;
            prev_on_reg   <= on;
            pending_reg   <= contour_end;
            start_off_reg <= start_off;
        end
    end

endmodule

FILE: hw/rtl/gopd_emit.sv
module gopd_emit #(
    parameter int POS_BITS        = gopd_pkg::POS_BITS_DEF,
    parameter int SCALE_FRAC_BITS = gopd_pkg::SCALE_FRAC_BITS_DEF
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            cfg_wr_en,
    input  logic [gopd_pkg::SCALE_W-1:0]                    cfg_wr_data,
    input  logic                                            take,
    input  gopd_pkg::job_ctl_t                              job_ctl,
    input  logic [gopd_pkg::MAX_RES-1:0][POS_BITS:0]        op_ax,
    input  logic [gopd_pkg::MAX_RES-1:0][POS_BITS:0]        op_ay,
    input  logic [gopd_pkg::MAX_RES-1:0][POS_BITS:0]        op_bx,
    input  logic [gopd_pkg::MAX_RES-1:0][POS_BITS:0]        op_by,
    output logic                                            job_ready,
    output logic                                            m_valid,
    input  logic                                            m_ready,
    output logic [2:0]                                      m_command,
    output logic signed [gopd_pkg::OUT_W-1:0]               m_p0_x,
    output logic signed [gopd_pkg::OUT_W-1:0]               m_p0_y,
    output logic signed [gopd_pkg::OUT_W-1:0]               m_p1_x,
    output logic signed [gopd_pkg::OUT_W-1:0]               m_p1_y,
    output logic                                            m_last
);
    import gopd_pkg::*;

    localparam int OP_W  = POS_BITS + 1;
    localparam int MUL_W = OP_W + SCALE_W + 1;
    localparam int EXT_W = (MUL_W > OUT_W) ? MUL_W : OUT_W;
    localparam int SHIFT = SCALE_FRAC_BITS - 15;

    logic [SCALE_W-1:0]                 scale_reg;
    logic                               job_valid_reg;
    job_ctl_t                           job_ctl_reg;
    logic [MAX_RES-1:0][OP_W-1:0]       ax_reg, ay_reg, bx_reg, by_reg;
    logic [IDX_W-1:0]                   idx_reg;

    logic                               m_valid_reg, m_last_reg;
    cmd_t                               m_cmd_reg;
    logic [OUT_W-1:0]                   p0_x_reg, p0_y_reg, p1_x_reg, p1_y_reg;

    logic                               out_load, last_entry, job_done, job_take;

    // Scale a doubled operand: floor(op * scale / 2^(frac - 15)), wrapped to OUT_W.
    function automatic logic [OUT_W-1:0] scale_op(
        input logic [OP_W-1:0]    op,
        input logic [SCALE_W-1:0] s
    );
        logic signed [MUL_W-1:0] prod;
        logic signed [EXT_W-1:0] ext;
        prod = MUL_W'($signed(op)) * $signed({1'b0, s});
        ext  = EXT_W'(prod);
        ext  = ext >>> SHIFT;
        return ext[OUT_W-1:0];
    endfunction

    // Result sequencing: one entry of the held command list per output slot.
    always_comb begin
        out_load   = job_valid_reg && (!m_valid_reg || m_ready);
        last_entry = (({1'b0, idx_reg}) + CNT_W'(1)) == job_ctl_reg.count;
        job_done   = out_load && last_entry;
        job_ready  = !job_valid_reg || job_done;
        job_take   = take && (job_ctl.count != '0);
    end

    // Scale register written from the configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_W'(1) << SCALE_FRAC_BITS;
        end else if (cfg_wr_en) begin
            scale_reg <= cfg_wr_data;
        end
    end

    // Command list register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (job_take) begin
            job_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end else if (job_done) begin
            job_valid_reg <= 1'b0;
        end else if (out_load) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (job_take) begin
            job_ctl_reg <= job_ctl;
            ax_reg      <= op_ax;
            ay_reg      <= op_ay;
            bx_reg      <= op_bx;
            by_reg      <= op_by;
        end
    end

    // Output register: scaled coordinates of the current entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_cmd_reg  <= job_ctl_reg.cmd[idx_reg];
            m_last_reg <= last_entry;
            p0_x_reg   <= scale_op(ax_reg[idx_reg], scale_reg);
            p0_y_reg   <= scale_op(ay_reg[idx_reg], scale_reg);
            p1_x_reg   <= scale_op(bx_reg[idx_reg], scale_reg);
            p1_y_reg   <= scale_op(by_reg[idx_reg], scale_reg);
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_command = m_cmd_reg;
    assign m_last    = m_last_reg;
    assign m_p0_x    = $signed(p0_x_reg);
    assign m_p0_y    = $signed(p0_y_reg);
    assign m_p1_x    = $signed(p1_x_reg);
    assign m_p1_y    = $signed(p1_y_reg);

endmodule

FILE: hw/rtl/glyph_outline_point_decoder_unit.sv
// Streaming outline decoder for simple glyphs. Each request on the s_ channel carries one
// outline point (expanded flag byte, raw x and y fields, glyph start and contour end marks);
// the block tracks the absolute position and issues MoveTo, LineTo, BezTo, start-point fixup
// and ClosePath requests on the m_ channel, with coordinates scaled by the scale register
// (unsigned, SCALE_FRAC_BITS fraction bits, reset to 1.0) into signed Q17.16. A point that
// causes zero or one result is taken every cycle while m_ready does not stall the output; a
// point that causes k results (up to four, at a contour end) holds s_ready low until its k
// results have each passed the single output register, which issues one result per cycle
// unless m_ready stalls it. Results pass the command list register, then the output
// register when free. Write the scale register only while no results are outstanding.
module glyph_outline_point_decoder_unit #(
    parameter int POS_BITS        = gopd_pkg::POS_BITS_DEF,
    parameter int SCALE_FRAC_BITS = gopd_pkg::SCALE_FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [gopd_pkg::SCALE_W-1:0]        cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_glyph_start,
    input  logic [gopd_pkg::FLAG_W-1:0]         s_flag,
    input  logic [gopd_pkg::RAW_W-1:0]          s_x_raw,
    input  logic [gopd_pkg::RAW_W-1:0]          s_y_raw,
    input  logic                                s_contour_end,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [2:0]                          m_command,
    output logic signed [gopd_pkg::OUT_W-1:0]   m_p0_x,
    output logic signed [gopd_pkg::OUT_W-1:0]   m_p0_y,
    output logic signed [gopd_pkg::OUT_W-1:0]   m_p1_x,
    output logic signed [gopd_pkg::OUT_W-1:0]   m_p1_y,
    output logic                                m_last
);
    import gopd_pkg::*;

    logic                             take;
    logic                             job_ready;
    job_ctl_t                         job_ctl;
    logic [MAX_RES-1:0][POS_BITS:0]   op_ax, op_ay, op_bx, op_by;

    // A request is taken when the command list stage is free or finishing.
    assign s_ready = job_ready;
    assign take    = s_valid && job_ready;

    // Point decode and outline state.
    gopd_decode #(
        .POS_BITS (POS_BITS)
    ) u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .glyph_start (s_glyph_start),
        .flag        (s_flag),
        .x_raw       (s_x_raw),
        .y_raw       (s_y_raw),
        .contour_end (s_contour_end),
        .job_ctl     (job_ctl),
        .op_ax       (op_ax),
        .op_ay       (op_ay),
        .op_bx       (op_bx),
        .op_by       (op_by)
    );

    // Result sequencing and scaling.
    gopd_emit #(
        .POS_BITS        (POS_BITS),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .take        (take),
        .job_ctl     (job_ctl),
        .op_ax       (op_ax),
        .op_ay       (op_ay),
        .op_bx       (op_bx),
        .op_by       (op_by),
        .job_ready   (job_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_command   (m_command),
        .m_p0_x      (m_p0_x),
        .m_p0_y      (m_p0_y),
        .m_p1_x      (m_p1_x),
        .m_p1_y      (m_p1_y),
        .m_last      (m_last)
    );

    // ClosePath always ends the results of its point.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_command == CMD_CLOSE) |-> m_last)
        else $error("ClosePath result without last");

    // A start-point fixup is always followed by more results of the same point.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_command == CMD_FIXUP) |-> !m_last)
        else $error("fixup result marked last");

    // ClosePath carries no coordinates.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_command == CMD_CLOSE) |->
            (m_p0_x == '0 && m_p0_y == '0 && m_p1_x == '0 && m_p1_y == '0))
        else $error("ClosePath with nonzero coordinates");

endmodule
